/* design/drflt_pkg.sv */
`timescale 1ns / 1ps

package drflt_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_UPDATE  = 2'd0,
    KIND_CONSUME = 2'd1,
    KIND_RESET   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_BYTES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_READY_LEVEL  = 1'b1;
  localparam int CFG_DATA_W = 32;

  // periods of headroom below the ring size before overrun
  localparam logic [1:0] OVERRUN_PERIODS = 2'd3;

  // one accepted input item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] period_number;
    logic [31:0] period_bytes;
    logic [31:0] request_bytes;
  } in_item_t;

  // period accounting handed to the level stage
  typedef struct packed {
    kind_t       kind;
    logic [31:0] request_bytes;
    logic [63:0] added_bytes;   // period delta times period size
    logic        full_wrap;     // 2^32 periods of a nonzero size: level saturates
    logic [31:0] threshold;     // overrun threshold, modulo 2^32
  } period_item_t;

endpackage

/* design/drflt_if.sv */
`timescale 1ns / 1ps

// input channel
interface drflt_in_if import drflt_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [31:0] period_number;
  logic [31:0] period_bytes;
  logic [31:0] request_bytes;

  modport source (output valid, output kind, output period_number, output period_bytes,
                  output request_bytes, input ready);
  modport sink   (input valid, input kind, input period_number, input period_bytes,
                  input request_bytes, output ready);
endinterface

// result channel
interface drflt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] level_bytes;
  logic [31:0] granted_bytes;
  logic        refused;
  logic        data_ready;
  logic        overrun;

  modport source (output valid, output level_bytes, output granted_bytes, output refused,
                  output data_ready, output overrun, input ready);
  modport sink   (input valid, input level_bytes, input granted_bytes, input refused,
                  input data_ready, input overrun, output ready);
endinterface

/* design/drflt_period_stage.sv */
`timescale 1ns / 1ps

module drflt_period_stage import drflt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  drflt_in_if.sink      in_ch,
  input  logic [31:0]   buffer_bytes,
  output logic          p_valid,
  output period_item_t  p_item,
  input  logic          p_ready
);

  logic         s1_valid;
  in_item_t     s1_item;
  logic         s2_valid;
  period_item_t s2_item;
  logic [31:0]  latched_period;
  logic [31:0]  last_period_number;

  logic         s2_load;
  logic [31:0]  period_eff;
  logic [31:0]  delta;
  logic [33:0]  period_x3;
  period_item_t s2_next;

  // handshake through the two registers
  assign s2_load      = s1_valid && (!s2_valid || p_ready);
  assign in_ch.ready  = !s1_valid || s2_load;
  assign p_valid      = s2_valid;
  assign p_item       = s2_item;

  // period size in force for this item, delta modulo 2^32, product and threshold
  always_comb begin
    period_eff = (latched_period == '0) ? s1_item.period_bytes : latched_period;
    delta      = s1_item.period_number - last_period_number;
    period_x3  = 34'(period_eff) * 34'(OVERRUN_PERIODS);
    s2_next.kind          = s1_item.kind;
    s2_next.request_bytes = s1_item.request_bytes;
    s2_next.added_bytes   = 64'(delta) * 64'(period_eff);
    s2_next.full_wrap     = (s1_item.period_number == last_period_number) &&
                            (period_eff != '0);
    s2_next.threshold     = buffer_bytes - period_x3[31:0];
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.kind          <= in_ch.kind;
      s1_item.period_number <= in_ch.period_number;
      s1_item.period_bytes  <= in_ch.period_bytes;
      s1_item.request_bytes <= in_ch.request_bytes;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || p_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_item <= s2_next;
    end
  end

  // updates advance the period number and latch the size; resets zero the number
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_period     <= '0;
      last_period_number <= '0;
    end else if (s2_load) begin
      case (s1_item.kind)
        KIND_UPDATE: begin
          latched_period     <= period_eff;
          last_period_number <= s1_item.period_number;
        end
        KIND_RESET: begin
          last_period_number <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // once latched, the period size never changes
  assert property (@(posedge clk) disable iff (rst)
    latched_period != '0 |=> latched_period == $past(latched_period))
    else $error("latched period size changed");

  // a stalled product holds
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !p_ready |=> s2_valid && $stable(s2_item))
    else $error("product register lost its item under stall");

  // a reset item restarts the period count
  assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_item.kind == KIND_RESET |=> last_period_number == '0)
    else $error("period number not cleared by reset item");

endmodule

/* design/drflt_level_stage.sv */
`timescale 1ns / 1ps

module drflt_level_stage import drflt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          p_valid,
  input  period_item_t  p_item,
  output logic          p_ready,
  input  logic [31:0]   ready_level,
  drflt_out_if.source   out_ch
);

  logic        out_valid;
  logic [31:0] fill_level;
  logic        overrun_flag;

  logic        load;
  logic [32:0] sum;
  logic        saturate;
  logic [31:0] update_level;
  logic [31:0] level_next;
  logic        overrun_next;
  logic [31:0] granted_next;
  logic        refused_next;

  assign p_ready       = !out_valid || out_ch.ready;
  assign load          = p_valid && p_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.level_bytes = fill_level;
  assign out_ch.overrun     = overrun_flag;

  // saturating add of the produced bytes
  always_comb begin
    sum          = {1'b0, fill_level} + {1'b0, p_item.added_bytes[31:0]};
    saturate     = p_item.full_wrap || (p_item.added_bytes[63:32] != '0) || sum[32];
    update_level = saturate ? '1 : sum[31:0];
  end

  // next level, flag and grant for each kind
  always_comb begin
    level_next   = fill_level;
    overrun_next = overrun_flag;
    granted_next = '0;
    refused_next = 1'b0;
    case (p_item.kind)
      KIND_UPDATE: begin
        level_next   = update_level;
        overrun_next = overrun_flag || (update_level > p_item.threshold);
      end
      KIND_CONSUME: begin
        if (p_item.request_bytes <= fill_level) begin
          level_next   = fill_level - p_item.request_bytes;
          granted_next = p_item.request_bytes;
        end else begin
          refused_next = 1'b1;
        end
      end
      KIND_RESET: begin
        level_next   = '0;
        overrun_next = 1'b0;
      end
      default: begin
        overrun_next = 1'b0;
      end
    endcase
  end

  // level state doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      fill_level   <= '0;
      overrun_flag <= 1'b0;
    end else begin
      if (p_ready) begin
        out_valid <= p_valid;
      end
      if (load) begin
        fill_level   <= level_next;
        overrun_flag <= overrun_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.granted_bytes <= granted_next;
      out_ch.refused       <= refused_next;
      out_ch.data_ready    <= (level_next >= ready_level);
    end
  end

  // a consume never raises the level
  assert property (@(posedge clk) disable iff (rst)
    load && p_item.kind == KIND_CONSUME |=> fill_level <= $past(fill_level))
    else $error("consume raised the fill level");

  // overrun only clears through a reset or clear item
  assert property (@(posedge clk) disable iff (rst)
    overrun_flag && !(load && (p_item.kind == KIND_RESET || p_item.kind == KIND_CLEAR))
    |=> overrun_flag)
    else $error("overrun flag dropped without a clearing item");

  // a refused request takes nothing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.refused |-> out_ch.granted_bytes == '0)
    else $error("refused transfer reports granted bytes");

endmodule

/* design/dma_ring_fill_level_tracker.sv */
`timescale 1ns / 1ps
// path: a result is registered in the input register, the product register and the
//   level/result register in turn
// throughput: one item per cycle unless the output stalls; the fill level is updated
//   by one 32-bit add and compare; the 32x32 period product comes a stage earlier
// reset: synchronous rst clears level, period state, overrun flag, config and valid bits

module dma_ring_fill_level_tracker import drflt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  drflt_in_if.sink               in_ch,
  drflt_out_if.source            out_ch,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [31:0]  buffer_bytes;
  logic [31:0]  ready_level;
  logic         p_valid;
  logic         p_ready;
  period_item_t p_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= '0;
      ready_level  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BUFFER_BYTES: buffer_bytes <= cfg_data;
        REG_READY_LEVEL:  ready_level  <= cfg_data;
      endcase
    end
  end

  drflt_period_stage u_period (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .buffer_bytes (buffer_bytes),
    .p_valid      (p_valid),
    .p_item       (p_item),
    .p_ready      (p_ready)
  );

  drflt_level_stage u_level (
    .clk         (clk),
    .rst         (rst),
    .p_valid     (p_valid),
    .p_item      (p_item),
    .p_ready     (p_ready),
    .ready_level (ready_level),
    .out_ch      (out_ch)
  );

endmodule
